>>> design/hslp_pkg.sv
// ----------------------------------------------------------------------------
// hslp_pkg
// Shared constants, codes and mixer constants of the linear-probing hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package hslp_pkg;

  // sizes
  localparam int CAPACITY_DEF = 1024;
  localparam int ID_W         = 63;
  localparam int KEY_W        = 64;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int SLOT_OUT_W   = 10;
  localparam int FILL_W       = 10;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  // queue between hash front and probe back
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = 3;
  localparam int Q_CNT_W = 4;

  localparam logic [FILL_W-1:0] MAX_FILL_RST = 10'd717;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  // splitmix64 finaliser
  localparam logic [KEY_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_C2     = 64'h94d049bb133111eb;
  localparam int MIX_SH0 = 30;
  localparam int MIX_SH1 = 27;
  localparam int MIX_SH2 = 31;

endpackage

`default_nettype wire

>>> design/hslp_ram.sv
// ----------------------------------------------------------------------------
// hslp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/hslp_front.sv
// ----------------------------------------------------------------------------
// hslp_front
// Input side: takes commands, forms the stored key and runs the 64-bit mixer
// through four register stages, then pushes the item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_front #(
  parameter int SLOT_W = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [hslp_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [hslp_pkg::ID_W-1:0]      in_id,
  input  wire logic                           hold,
  input  wire logic                           pop,
  output logic                                push,
  output logic [SLOT_W+hslp_pkg::KEY_W+hslp_pkg::CMD_W-1:0] push_data
);

  localparam int KW = hslp_pkg::KEY_W;
  localparam int CW = hslp_pkg::CMD_W;
  localparam logic [KW-1:0]   GOLD_P1 = hslp_pkg::MIX_GOLDEN + 64'd1;
  localparam logic [31:0]     C1_LO   = hslp_pkg::MIX_C1[31:0];
  localparam logic [31:0]     C1_HI   = hslp_pkg::MIX_C1[63:32];
  localparam logic [31:0]     C2_LO   = hslp_pkg::MIX_C2[31:0];
  localparam logic [31:0]     C2_HI   = hslp_pkg::MIX_C2[63:32];

  // items in flight plus items queued
  logic [hslp_pkg::Q_CNT_W-1:0] occ_r, occ_nxt;
  logic                         enter;

  logic          vld1_r, vld2_r, vld3_r, vld4_r;
  logic [CW-1:0] cmd1_r, cmd2_r, cmd3_r, cmd4_r;
  logic [KW-1:0] key1_r, key2_r, key3_r, key4_r;

  logic [KW-1:0] key0, v0;
  logic [KW-1:0] a1_r;
  logic [KW-1:0] pll_s, pll2_r;
  logic [31:0]   phl_s, plh_s, phl2_r, plh2_r;
  logic [KW-1:0] w3, b3_r;
  logic [KW-1:0] qll_s, qll4_r;
  logic [31:0]   qhl_s, qlh_s, qhl4_r, qlh4_r;
  logic [KW-1:0] x5, h5;
  logic [31:0]   sum2, sum4;

  assign in_ready = !hold && (occ_r < hslp_pkg::Q_CNT_W'(hslp_pkg::Q_DEPTH));
  assign enter    = in_valid && in_ready && (in_cmd != hslp_pkg::CMD_NONE);

  always_comb begin
    occ_nxt = occ_r;
    if (enter && !pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!enter && pop) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  // stage 1: key = id + 1, v = key + golden, xor-shift
  assign key0 = {1'b0, in_id} + 64'd1;
  assign v0   = {1'b0, in_id} + GOLD_P1;

  // stage 2: low 64 bits of a1 * c1 as three partial products
  assign pll_s = a1_r[31:0] * C1_LO;
  assign phl_s = a1_r[63:32] * C1_LO;
  assign plh_s = a1_r[31:0] * C1_HI;

  assign sum2 = phl2_r + plh2_r;
  assign w3   = pll2_r + {sum2, 32'd0};

  assign qll_s = b3_r[31:0] * C2_LO;
  assign qhl_s = b3_r[63:32] * C2_LO;
  assign qlh_s = b3_r[31:0] * C2_HI;

  assign sum4 = qhl4_r + qlh4_r;
  assign x5   = qll4_r + {sum4, 32'd0};
  assign h5   = x5 ^ (x5 >> hslp_pkg::MIX_SH2);

  assign push      = vld4_r;
  assign push_data = {h5[SLOT_W-1:0], key4_r, cmd4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      vld1_r <= enter;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_cmd;
    key1_r <= key0;
    a1_r   <= v0 ^ (v0 >> hslp_pkg::MIX_SH0);
    cmd2_r <= cmd1_r;
    key2_r <= key1_r;
    pll2_r <= pll_s;
    phl2_r <= phl_s;
    plh2_r <= plh_s;
    cmd3_r <= cmd2_r;
    key3_r <= key2_r;
    b3_r   <= w3 ^ (w3 >> hslp_pkg::MIX_SH1);
    cmd4_r <= cmd3_r;
    key4_r <= key3_r;
    qll4_r <= qll_s;
    qhl4_r <= qhl_s;
    qlh4_r <= qlh_s;
  end

endmodule

`default_nettype wire

>>> design/hslp_queue.sv
// ----------------------------------------------------------------------------
// hslp_queue
// Short first-in first-out queue between the hash front and the probe back.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_queue #(
  parameter int WIDTH = 76
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] head
);

  logic [WIDTH-1:0]                 entry_r [hslp_pkg::Q_DEPTH];
  logic [hslp_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [hslp_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/hslp_back.sv
// ----------------------------------------------------------------------------
// hslp_back
// Probe engine: walks the slot table one slot per cycle from the home slot,
// inserts or reports, sweeps the table on clear and after reset, and holds
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_back #(
  parameter int CAPACITY = 1024,
  parameter int SLOT_W   = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [hslp_pkg::FILL_W-1:0]        max_fill,
  input  wire logic                               q_empty,
  input  wire logic [SLOT_W+hslp_pkg::KEY_W+hslp_pkg::CMD_W-1:0] q_head,
  output logic                                    q_pop,
  output logic                                    init_busy,
  output logic                                    ram_we,
  output logic      [SLOT_W-1:0]                  ram_waddr,
  output logic      [hslp_pkg::KEY_W-1:0]         ram_wdata,
  output logic      [SLOT_W-1:0]                  ram_raddr,
  input  wire logic [hslp_pkg::KEY_W-1:0]         ram_rdata,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [hslp_pkg::STATUS_W-1:0]      out_status,
  output logic      [hslp_pkg::SLOT_OUT_W-1:0]    out_slot
);

  localparam int KW    = hslp_pkg::KEY_W;
  localparam int CW    = hslp_pkg::CMD_W;
  localparam int LIM_W = (SLOT_W > hslp_pkg::FILL_W) ? SLOT_W : hslp_pkg::FILL_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [LIM_W-1:0]  CAP_LIM   = LIM_W'(CAPACITY - 1);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] count_r, count_nxt;
  logic              report_r, report_nxt;
  logic [CW-1:0]     cmd_r, cmd_nxt;
  logic [KW-1:0]     key_r, key_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [hslp_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [hslp_pkg::SLOT_OUT_W-1:0]   out_slot_r, out_slot_nxt;

  logic [CW-1:0]     h_cmd;
  logic [KW-1:0]     h_key;
  logic [SLOT_W-1:0] h_home;

  logic              out_free, hit, vacant, full;
  logic [LIM_W-1:0]  fill_ext, limit, count_ext, pos_ext;

  assign h_cmd  = q_head[CW-1:0];
  assign h_key  = q_head[CW+KW-1:CW];
  assign h_home = q_head[CW+KW+SLOT_W-1:CW+KW];

  assign out_free  = !out_valid_r || out_ready;
  assign hit       = (ram_rdata == key_r);
  assign vacant    = (ram_rdata == '0);
  assign fill_ext  = LIM_W'(max_fill);
  assign limit     = (fill_ext > CAP_LIM) ? CAP_LIM : fill_ext;
  assign count_ext = LIM_W'(count_r);
  assign pos_ext   = LIM_W'(pos_r);
  assign full      = (count_ext >= limit);

  assign init_busy = (state_r == S_SWEEP) && !report_r;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    report_nxt     = report_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = '0;
    ram_raddr      = pos_r;

    unique case (state_r)
      S_SWEEP: begin
        ram_we = 1'b1;
        if (pos_r == LAST_SLOT) begin
          if (!report_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = hslp_pkg::ST_CLEARED;
            out_slot_nxt   = '0;
            report_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = h_cmd;
          key_nxt = h_key;
          if (h_cmd == hslp_pkg::CMD_CLEAR) begin
            pos_nxt    = '0;
            count_nxt  = '0;
            report_nxt = 1'b1;
            state_nxt  = S_SWEEP;
          end else begin
            pos_nxt   = h_home;
            ram_raddr = h_home;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (hit || vacant) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (cmd_r == hslp_pkg::CMD_QUERY) begin
              out_status_nxt = hit ? hslp_pkg::ST_FOUND : hslp_pkg::ST_MISSING;
              out_slot_nxt   = hit ? pos_ext[hslp_pkg::SLOT_OUT_W-1:0] : '0;
            end else if (hit) begin
              out_status_nxt = hslp_pkg::ST_DUP;
              out_slot_nxt   = pos_ext[hslp_pkg::SLOT_OUT_W-1:0];
            end else if (full) begin
              out_status_nxt = hslp_pkg::ST_FULL;
              out_slot_nxt   = '0;
            end else begin
              ram_we         = 1'b1;
              ram_wdata      = key_r;
              count_nxt      = count_r + 1'b1;
              out_status_nxt = hslp_pkg::ST_ADDED;
              out_slot_nxt   = pos_ext[hslp_pkg::SLOT_OUT_W-1:0];
            end
          end
        end else begin
          // occupied by another key: step to the next slot, wrapping
          pos_nxt   = pos_r + 1'b1;
          ram_raddr = pos_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      pos_r       <= '0;
      count_r     <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

`default_nettype wire

>>> design/hash_set_linear_probe.sv
// ----------------------------------------------------------------------------
// hash_set_linear_probe
// Fixed-capacity set of 63-bit ids with linear probing over a slot RAM.
// ----------------------------------------------------------------------------
// Each command goes through a four-stage splitmix64 pipeline, then a small
// queue, then the probe engine, which reads one RAM slot per cycle from the
// home slot until it meets the key or an empty slot. An insert or query
// therefore occupies the probe engine while it takes the item from the
// queue and reads each slot probed, after the registered hash pipeline. A
// clear empties the RAM one slot a cycle, over every slot, and then
// reports. After reset the same pass runs while in_tready stays low;
// configuration writes are taken throughout. CAPACITY must be a power of
// two, since the home slot is the low hash bits. cmd 3 is taken and gives
// no result.
`default_nettype none

module hash_set_linear_probe #(
  parameter int CAPACITY = hslp_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: key_id [62:0], zero [63]
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [hslp_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: cmd [1:0]
  input  wire logic [hslp_pkg::CMD_W-1:0]          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_tdata: slot [9:0], zero [15:10]
  output logic      [hslp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: status [2:0]
  output logic      [hslp_pkg::STATUS_W-1:0]       out_tuser,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [hslp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [hslp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [hslp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int Q_W    = SLOT_W + hslp_pkg::KEY_W + hslp_pkg::CMD_W;

  logic [hslp_pkg::FILL_W-1:0] max_fill_r;
  logic                        cfg_wr;

  logic                        push, pop, q_empty, init_busy;
  logic [Q_W-1:0]              push_data, q_head;
  logic                        ram_we;
  logic [SLOT_W-1:0]           ram_waddr, ram_raddr;
  logic [hslp_pkg::KEY_W-1:0]  ram_wdata, ram_rdata;
  logic [hslp_pkg::SLOT_OUT_W-1:0] slot;

  // register file: max_fill at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? '0 : hslp_pkg::CFG_DATA_W'(max_fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fill_r <= hslp_pkg::MAX_FILL_RST;
    end else if (cfg_wr) begin
      max_fill_r <= cfg_pwdata[hslp_pkg::FILL_W-1:0];
    end
  end

  hslp_front #(
    .SLOT_W (SLOT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_id     (in_tdata[hslp_pkg::ID_W-1:0]),
    .hold      (init_busy),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  hslp_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  hslp_back #(
    .CAPACITY (CAPACITY),
    .SLOT_W   (SLOT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_fill   (max_fill_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (pop),
    .init_busy  (init_busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_slot   (slot)
  );

  hslp_ram #(
    .WIDTH (hslp_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = hslp_pkg::OUT_DATA_W'(slot);

endmodule

`default_nettype wire

>>> design/hslp_checker.sv
// ----------------------------------------------------------------------------
// hslp_checker
// Port-level checks on the hash set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [hslp_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [hslp_pkg::STATUS_W-1:0]   out_tuser
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // nothing comes out and nothing is taken in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity straight after reset");

  // status codes above cleared never appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= hslp_pkg::ST_CLEARED))
    else $error("undefined status code");

  // full, not found and cleared carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == hslp_pkg::ST_FULL || out_tuser == hslp_pkg::ST_MISSING ||
                   out_tuser == hslp_pkg::ST_CLEARED) |-> (out_tdata == '0))
    else $error("nonzero slot on a miss");

endmodule

bind hash_set_linear_probe hslp_checker u_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear-probing hash set. A directed table covers
// empty set, id extremes, wrap from the last slot, fill limit, clear and the
// unused command. Random phases then run under several fill limits.
// ----------------------------------------------------------------------------
// Every accepted command is run through a software copy of the set to work out
// its result. Results are checked in order, field by field, while both stream
// sides idle and stall at random.

module testbench;
  import hslp_pkg::*;

  localparam int SET_SIZE = CAPACITY_DEF;
  localparam logic [CFG_ADDR_W-1:0] FILL_REG_ADDR = '0;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 105;
  localparam int ID_POOL_MAX = 400;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
  } set_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_DATA_W-1:0] cfg_value;
    logic [CMD_W-1:0]      cmd;
    logic [ID_W-1:0]       id;
    bit                    known;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = CMD_INSERT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // software copy of the set
  logic [KEY_W-1:0]  set_keys [SET_SIZE];
  int                stored_count = 0;
  logic [FILL_W-1:0] fill_limit = MAX_FILL_RST;

  set_result_t       expected_results [$];
  logic [ID_W-1:0]   known_ids [$];
  stim_row_t         directed_rows [$];

  int errors = 0;
  int commands_sent = 0;
  int fill_settings = 0;
  int status_count [6];
  int calm_left = 0;
  int steady_left = 0;
  int stall_left = 0;

  hash_set_linear_probe #(
    .CAPACITY(SET_SIZE)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int home_slot(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] v;
    v = key + MIX_GOLDEN;
    v = (v ^ (v >> MIX_SH0)) * MIX_C1;
    v = (v ^ (v >> MIX_SH1)) * MIX_C2;
    v = v ^ (v >> MIX_SH2);
    return int'(v % SET_SIZE);
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input logic [ID_W-1:0] id);
    return {1'b0, id} + 64'd1;
  endfunction

  // insert / query / clear on the software copy
  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic [ID_W-1:0] id,
                                        output bit produces,
                                        output set_result_t res);
    logic [KEY_W-1:0] key;
    int pos;
    bit hit;
    key = key_of(id);
    produces = 1'b1;
    res.status = ST_CLEARED;
    res.slot = '0;
    case (cmd)
      CMD_CLEAR: begin
        foreach (set_keys[i]) set_keys[i] = '0;
        stored_count = 0;
      end
      CMD_NONE: begin
        produces = 1'b0;
      end
      default: begin
        pos = home_slot(key);
        hit = 1'b0;
        for (int n = 0; n < SET_SIZE; n++) begin
          if (set_keys[pos] == key) begin
            hit = 1'b1;
            break;
          end
          if (set_keys[pos] == '0) break;
          pos = (pos + 1) % SET_SIZE;
        end
        if (cmd == CMD_QUERY) begin
          res.status = hit ? ST_FOUND : ST_MISSING;
          res.slot = hit ? SLOT_OUT_W'(pos) : '0;
        end else if (hit) begin
          res.status = ST_DUP;
          res.slot = SLOT_OUT_W'(pos);
        // a 10-bit limit never exceeds capacity - 1, so no clamp is needed
        end else if (stored_count >= int'(fill_limit)) begin
          res.status = ST_FULL;
        end else begin
          set_keys[pos] = key;
          stored_count++;
          res.status = ST_ADDED;
          res.slot = SLOT_OUT_W'(pos);
        end
      end
    endcase
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ID_W-1:0];
  endfunction

  function automatic void remember_id(input logic [ID_W-1:0] id);
    if (known_ids.size() >= ID_POOL_MAX)
      known_ids.delete($urandom_range(0, known_ids.size() - 1));
    known_ids.push_back(id);
  endfunction

  // often ids already seen, some that share a home slot with one of them, some id extremes, else fresh ids
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    int target;
    logic [ID_W-1:0] cand;
    r = $urandom_range(0, 99);
    if (known_ids.size() > 0 && r < 45)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    if (known_ids.size() > 0 && r < 58) begin
      target = home_slot(key_of(known_ids[$urandom_range(0, known_ids.size() - 1)]));
      for (int n = 0; n < 16384; n++) begin
        cand = fresh_id();
        if (home_slot(key_of(cand)) == target) break;
      end
      remember_id(cand);
      return cand;
    end
    if (r < 64) begin
      case ($urandom_range(0, 3))
        0: cand = '0;
        1: cand = '1;
        2: cand = ID_W'($urandom_range(0, 63));
        default: cand = {1'b1, 62'($urandom)};
      endcase
      remember_id(cand);
      return cand;
    end
    cand = fresh_id();
    remember_id(cand);
    return cand;
  endfunction

  function automatic int input_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit ready_next();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 80);
      return 1'b1;
    end
    if (r < 4) stall_left = $urandom_range(15, 50);
    else if (r < 30) stall_left = $urandom_range(1, 3);
    else return 1'b1;
    stall_left--;
    return 1'b0;
  endfunction

  function automatic stim_row_t row_cmd(input logic [CMD_W-1:0] cmd,
                                        input logic [ID_W-1:0] id);
    stim_row_t row;
    row = '{1'b0, '0, cmd, id, 1'b0, ST_ADDED, '0};
    return row;
  endfunction

  function automatic stim_row_t row_known(input logic [CMD_W-1:0] cmd,
                                          input logic [ID_W-1:0] id,
                                          input logic [STATUS_W-1:0] status);
    stim_row_t row;
    row = '{1'b0, '0, cmd, id, 1'b1, status, '0};
    return row;
  endfunction

  function automatic stim_row_t row_cfg(input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '{1'b1, value, CMD_NONE, '0, 1'b0, ST_ADDED, '0};
    return row;
  endfunction

  // tvalid stays high after a transaction; the next call either moves on
  // to new data or drops it, so it is assigned once per step
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input bit known, input set_result_t known_res);
    int gap;
    bit produces;
    set_result_t res;
    gap = input_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {1'b0, id};
    do @(posedge clk); while (!in_tready);
    apply_command(cmd, id, produces, res);
    if (known) res = known_res;
    if (produces) expected_results.push_back(res);
    commands_sent++;
  endtask

  // drop tvalid, wait for every result, then let the design settle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_fill_limit(input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] want;
    want = CFG_DATA_W'(value[FILL_W-1:0]);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= FILL_REG_ADDR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fill_limit = value[FILL_W-1:0];
    fill_settings++;
    // read back straight away
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("max_fill read back: expected %0d, got %0d", want, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: status %0d slot %0d", out_tuser, out_tdata[9:0]);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[SLOT_OUT_W-1:0] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_tdata[SLOT_OUT_W-1:0]);
          errors++;
        end
        status_count[want.status]++;
      end
    end
    out_tready <= ready_next();
  end

  initial begin
    logic [ID_W-1:0] wrap_id [2];
    logic [ID_W-1:0] cand;
    logic [CMD_W-1:0] cmd;
    logic [CFG_DATA_W-1:0] limit_value;
    set_result_t known_res;
    int found;
    int r;

    foreach (set_keys[i]) set_keys[i] = '0;
    foreach (status_count[i]) status_count[i] = 0;

    // two ids whose home is the last slot, so the second wraps to the start
    found = 0;
    while (found < 2) begin
      cand = fresh_id();
      if (home_slot(key_of(cand)) == SET_SIZE - 1) begin
        wrap_id[found] = cand;
        found++;
      end
    end

    directed_rows.push_back(row_known(CMD_QUERY, '0, ST_MISSING));
    directed_rows.push_back(row_cmd(CMD_INSERT, '0));
    directed_rows.push_back(row_cmd(CMD_INSERT, '0));
    directed_rows.push_back(row_cmd(CMD_QUERY, '0));
    directed_rows.push_back(row_cmd(CMD_INSERT, '1));
    directed_rows.push_back(row_cmd(CMD_QUERY, '1));
    directed_rows.push_back(row_cmd(CMD_INSERT, wrap_id[0]));
    directed_rows.push_back(row_cmd(CMD_INSERT, wrap_id[1]));
    directed_rows.push_back(row_cmd(CMD_QUERY, wrap_id[1]));
    directed_rows.push_back(row_cmd(CMD_NONE, '1));
    directed_rows.push_back(row_cmd(CMD_INSERT, 63'd1));
    // limit of one, already exceeded: new ids rejected, duplicates still seen
    directed_rows.push_back(row_cfg(32'd1));
    directed_rows.push_back(row_known(CMD_INSERT, 63'd12345, ST_FULL));
    directed_rows.push_back(row_cmd(CMD_INSERT, '0));
    directed_rows.push_back(row_known(CMD_CLEAR, '1, ST_CLEARED));
    directed_rows.push_back(row_known(CMD_QUERY, '0, ST_MISSING));
    directed_rows.push_back(row_cmd(CMD_INSERT, 63'd77));
    directed_rows.push_back(row_known(CMD_INSERT, 63'd78, ST_FULL));
    // zero limit, upper data bits set and ignored
    directed_rows.push_back(row_cfg(32'hffff_fc00));
    directed_rows.push_back(row_known(CMD_CLEAR, '0, ST_CLEARED));
    directed_rows.push_back(row_known(CMD_INSERT, 63'd5, ST_FULL));
    directed_rows.push_back(row_known(CMD_QUERY, 63'd5, ST_MISSING));
    directed_rows.push_back(row_cfg(32'd1023));
    directed_rows.push_back(row_cmd(CMD_INSERT, ID_W'({32{2'b10}})));
    directed_rows.push_back(row_cmd(CMD_INSERT, ID_W'({32{2'b01}})));
    directed_rows.push_back(row_cmd(CMD_QUERY, ID_W'({32{2'b10}})));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        program_fill_limit(directed_rows[i].cfg_value);
      end else begin
        known_res.status = directed_rows[i].status;
        known_res.slot = directed_rows[i].slot;
        send_command(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].known,
                     known_res);
      end
    end

    known_res = '0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: limit_value = 32'd1023;
        1: limit_value = 32'd1;
        2: limit_value = $urandom_range(2, 40);
        3: limit_value = CFG_DATA_W'(MAX_FILL_RST);
        4: limit_value = $urandom_range(1, 1023);
        5: limit_value = $urandom_range(41, 200);
        6: limit_value = $urandom;
        default: limit_value = $urandom_range(300, 600);
      endcase
      settle();
      program_fill_limit(limit_value);
      if ($urandom_range(0, 1) == 1) send_command(CMD_CLEAR, fresh_id(), 1'b0, known_res);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 199);
        if (r < 2) cmd = CMD_CLEAR;
        else if (r < 8) cmd = CMD_NONE;
        else if (r < 110) cmd = CMD_INSERT;
        else cmd = CMD_QUERY;
        send_command(cmd, pick_id(), 1'b0, known_res);
      end
    end

    settle();
    $display("%0d commands under %0d fill-limit settings", commands_sent, fill_settings);
    $display("added %0d, duplicate %0d, full %0d, found %0d, not found %0d, cleared %0d",
             status_count[ST_ADDED], status_count[ST_DUP], status_count[ST_FULL],
             status_count[ST_FOUND], status_count[ST_MISSING], status_count[ST_CLEARED]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
